// ===== design/ihcp_pkg.sv =====
// ============================================================================
// ihcp_pkg
// Shared types, constants and helpers for the IPv6 header chain parser.
// ============================================================================
package ihcp_pkg;

    // Byte position counter width; the count saturates at all ones
    localparam int POSITION_BITS = 17;
    // Width wide enough for a header start plus the largest extension length
    localparam int SUM_BITS      = (POSITION_BITS + 1 > 13) ? POSITION_BITS + 1 : 13;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [SUM_BITS-1:0]      pos_sum_t;

    localparam pos_t POS_MAX   = '1;
    localparam pos_t FIXED_LEN = POSITION_BITS'(40);
    localparam pos_t FIXED_HDR = POSITION_BITS'(8);
    localparam pos_t NH_POS    = POSITION_BITS'(6);
    localparam int   EXT_UNIT  = 8;

    // Next header codes
    localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] NH_TCP        = 8'd6;
    localparam logic [7:0] NH_UDP        = 8'd17;
    localparam logic [7:0] NH_ROUTING    = 8'd43;
    localparam logic [7:0] NH_FRAGMENT   = 8'd44;
    localparam logic [7:0] NH_ICMPV6     = 8'd58;
    localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

    // Result status codes
    localparam logic [2:0] ST_TOO_SHORT = 3'd0;
    localparam logic [2:0] ST_UPPER     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    localparam logic [1:0] PART_LAST = 2'd3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] base_offset;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  version;
        logic [7:0]  tclass;
        logic [19:0] flow_id;
        logic [15:0] pay_len;
        logic [7:0]  hop_lim;
        logic [7:0]  first_next_header;
        logic [7:0]  upper_protocol;
        logic [15:0] upper_offset;
        logic [1:0]  address_part;
        logic [63:0] address_word;
        logic        last_result;
    } out_item_t;

    // Per-packet summary handed from the walker to the emitter
    typedef struct packed {
        logic        too_short;
        logic [2:0]  status;
        logic [3:0]  version;
        logic [7:0]  tclass;
        logic [19:0] flow_id;
        logic [15:0] pay_len;
        logic [7:0]  hop_lim;
        logic [7:0]  first_next_header;
        logic [7:0]  upper_protocol;
        logic [15:0] upper_offset;
    } summary_t;

    typedef logic [3:0][63:0] addr_set_t;

    function automatic logic is_upper(input logic [7:0] nh);
        return (nh == NH_TCP) || (nh == NH_UDP) || (nh == NH_ICMPV6);
    endfunction

    function automatic logic is_len_ext(input logic [7:0] nh);
        return (nh == NH_HOP_BY_HOP) || (nh == NH_ROUTING) || (nh == NH_DEST_OPTS);
    endfunction

    function automatic pos_t sat_pos(input pos_sum_t v);
        return (v > SUM_BITS'(POS_MAX)) ? POS_MAX : POSITION_BITS'(v);
    endfunction

endpackage

// ===== design/ihcp_in_stage.sv =====
// ============================================================================
// ihcp_in_stage
// Input register for packet bytes; holds a last byte while the emitter is busy.
// ============================================================================
module ihcp_in_stage
    import ihcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid,
    output logic     stall,
    input  in_item_t item,
    input  logic     emit_free,
    output logic     advance,
    output in_item_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Pass the held item on unless it closes a packet and the emitter is full
    assign advance   = valid_reg && (!item_reg.last_byte || emit_free);
    assign stall     = valid_reg && !advance;
    assign held_item = item_reg;

    // Refill whenever the held item moves on or the register is empty
    always_comb
    begin
        valid_next = valid_reg;
        if (valid && !stall)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            item_reg <= item;
        end
    end

endmodule

// ===== design/ihcp_walker.sv =====
// ============================================================================
// ihcp_walker
// Per-byte header capture and extension header walk; builds the packet summary.
// ============================================================================
module ihcp_walker
    import ihcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    output logic      load,
    output summary_t  summary,
    output addr_set_t addrs
);

    pos_t        pos_reg,     pos_next;
    logic [15:0] base_reg,    base_next;
    logic [63:0] fixed_reg,   fixed_next;
    logic [7:0]  wnh_reg,     wnh_next;
    pos_t        hs_reg,      hs_next;
    pos_t        he_reg,      he_next;
    logic        stopped_reg, stopped_next;
    logic [2:0]  stop_reg,    stop_next;
    logic [7:0]  pend_reg,    pend_next;
    logic [63:0] addr_reg [4];

    pos_t        addr_off;
    logic        addr_we;

    assign load     = advance && item.last_byte;
    assign addr_off = pos_reg - FIXED_HDR;
    assign addr_we  = advance && (pos_reg != POS_MAX) && (pos_reg >= FIXED_HDR)
                      && (pos_reg < FIXED_LEN);

    // Present the address quarters with the current byte already shifted in
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            addrs[i] = addr_reg[i];
            if (addr_we && (addr_off[4:3] == 2'(i)))
            begin
                addrs[i] = {addr_reg[i][55:0], item.data_byte};
            end
        end
    end

    // Update parse state for one byte, build the summary on the last byte
    always_comb
    begin
        pos_t        p;
        logic [7:0]  b;
        pos_t        start;
        logic [7:0]  proto;
        logic [2:0]  st;
        pos_sum_t    hs_inc;

        p            = pos_reg;
        b            = item.data_byte;
        pos_next     = pos_reg;
        base_next    = base_reg;
        fixed_next   = fixed_reg;
        wnh_next     = wnh_reg;
        hs_next      = hs_reg;
        he_next      = he_reg;
        stopped_next = stopped_reg;
        stop_next    = stop_reg;
        pend_next    = pend_reg;
        summary      = '0;
        start        = '0;
        proto        = '0;
        st           = ST_TOO_SHORT;
        hs_inc       = '0;

        if (advance && (p != POS_MAX))
        begin
            if (p == '0)
            begin
                base_next = item.base_offset;
            end
            if (p < FIXED_HDR)
            begin
                fixed_next = {fixed_reg[55:0], b};
            end
            if (p == NH_POS)
            begin
                wnh_next = b;
            end

            // Walk extension headers past the fixed header
            if (!stopped_reg && (p >= FIXED_LEN))
            begin
                if ((he_next > hs_next) && (p == he_next))
                begin
                    wnh_next = pend_reg;
                    hs_next  = he_next;
                end
                hs_inc = SUM_BITS'(hs_next) + SUM_BITS'(1);
                if (p == hs_next)
                begin
                    if (is_upper(wnh_next))
                    begin
                        stopped_next = 1'b1;
                        stop_next    = ST_UPPER;
                    end
                    else if (is_len_ext(wnh_next) || (wnh_next == NH_FRAGMENT))
                    begin
                        pend_next = b;
                        he_next   = sat_pos(SUM_BITS'(hs_next) + SUM_BITS'(EXT_UNIT));
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                        stop_next    = ST_UNKNOWN;
                    end
                end
                else if ((SUM_BITS'(p) == hs_inc) && is_len_ext(wnh_next))
                begin
                    he_next = sat_pos(SUM_BITS'(hs_next) + SUM_BITS'({b, 3'b000})
                                      + SUM_BITS'(EXT_UNIT));
                end
            end
            pos_next = p + POSITION_BITS'(1);
        end

        if (load)
        begin
            // Decide where the walk ended
            proto = wnh_next;
            start = hs_next;
            if (stopped_next)
            begin
                st = stop_next;
            end
            else if (he_next > hs_next)
            begin
                if (pos_next >= he_next)
                begin
                    proto = pend_next;
                    start = he_next;
                    st    = ST_EXHAUSTED;
                end
                else
                begin
                    st = ST_TRUNCATED;
                end
            end
            else
            begin
                st = ST_EXHAUSTED;
            end

            if (pos_next < FIXED_LEN)
            begin
                summary.too_short = 1'b1;
            end
            else
            begin
                summary.status            = st;
                summary.version           = fixed_next[63:60];
                summary.tclass            = fixed_next[59:52];
                summary.flow_id           = fixed_next[51:32];
                summary.pay_len           = fixed_next[31:16];
                summary.hop_lim           = fixed_next[7:0];
                summary.first_next_header = fixed_next[15:8];
                summary.upper_protocol    = proto;
                summary.upper_offset      = base_next + 16'(start);
            end

            // Return to the idle state for the next packet
            pos_next     = '0;
            base_next    = '0;
            fixed_next   = '0;
            wnh_next     = '0;
            hs_next      = FIXED_LEN;
            he_next      = FIXED_LEN;
            stopped_next = 1'b0;
            stop_next    = ST_TOO_SHORT;
            pend_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            base_reg    <= '0;
            fixed_reg   <= '0;
            wnh_reg     <= '0;
            hs_reg      <= FIXED_LEN;
            he_reg      <= FIXED_LEN;
            stopped_reg <= 1'b0;
            stop_reg    <= ST_TOO_SHORT;
            pend_reg    <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            base_reg    <= base_next;
            fixed_reg   <= fixed_next;
            wnh_reg     <= wnh_next;
            hs_reg      <= hs_next;
            he_reg      <= he_next;
            stopped_reg <= stopped_next;
            stop_reg    <= stop_next;
            pend_reg    <= pend_next;
        end
    end

    // Shift address bytes into the selected quarter
    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_reg[addr_off[4:3]] <= {addr_reg[addr_off[4:3]][55:0], item.data_byte};
        end
    end

endmodule

// ===== design/ihcp_emitter.sv =====
// ============================================================================
// ihcp_emitter
// Result buffer; holds one packet summary and sends its result items in turn.
// ============================================================================
module ihcp_emitter
    import ihcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  summary_t  summary,
    input  addr_set_t addrs,
    output logic      emit_free,
    output logic      valid,
    input  logic      stall,
    output out_item_t item
);

    logic        valid_reg,  valid_next;
    logic [1:0]  part_reg,   part_next;
    summary_t    sum_reg;
    logic [63:0] addr_reg [4];
    logic        final_item;

    assign final_item = sum_reg.too_short || (part_reg == PART_LAST);
    assign emit_free  = !valid_reg || (!stall && final_item);
    assign valid      = valid_reg;

    // Assemble the current result item
    always_comb
    begin
        item.status            = sum_reg.status;
        item.version           = sum_reg.version;
        item.tclass            = sum_reg.tclass;
        item.flow_id           = sum_reg.flow_id;
        item.pay_len           = sum_reg.pay_len;
        item.hop_lim           = sum_reg.hop_lim;
        item.first_next_header = sum_reg.first_next_header;
        item.upper_protocol    = sum_reg.upper_protocol;
        item.upper_offset      = sum_reg.upper_offset;
        item.address_part      = part_reg;
        item.address_word      = sum_reg.too_short ? 64'd0 : addr_reg[part_reg];
        item.last_result       = final_item;
    end

    // Advance through the quarters, reload on a new summary
    always_comb
    begin
        valid_next = valid_reg;
        part_next  = part_reg;
        if (load)
        begin
            valid_next = 1'b1;
            part_next  = '0;
        end
        else if (valid_reg && !stall)
        begin
            if (final_item)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                part_next = part_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            part_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            part_reg  <= part_next;
        end
    end

    // Hold a snapshot of the packet summary
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= summary;
            for (int i = 0; i < 4; i++)
            begin
                addr_reg[i] <= addrs[i];
            end
        end
    end

endmodule

// ===== design/ipv6_header_chain_parser_core.sv =====
// ============================================================================
// ipv6_header_chain_parser_core
// IPv6 fixed header extraction and extension header chain walk, byte by byte.
// ============================================================================
// Usage:
//   Packet bytes enter on the byte channel (byte_valid / byte_stall /
//   byte_item), starting at the first IPv6 header byte; base_offset is taken
//   from the first byte and last_byte marks the end of the packet.
//   Results leave on the result channel (result_valid / result_stall /
//   result_item): four items per packet of 40 bytes or more, one per address
//   quarter, or one too-short item; last_result flags the final one.
//   Throughput is one byte per cycle while byte_stall is low. Each byte
//   passes the input register, then the parse state; a last byte leaving
//   the input register loads the single result buffer, which presents the
//   first result; the remaining results follow one per cycle while
//   result_stall is low. A last byte waits in the input register while the
//   result buffer still holds an earlier packet, so a stalled receiver
//   backs up into byte_stall only at packet ends. Reset clears all parse
//   state and drops pending results; byte_stall is low out of reset.
// ============================================================================
module ipv6_header_chain_parser_core
    import ihcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_item_t  byte_item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result_item
);

    logic      emit_free;
    logic      advance;
    in_item_t  held_item;
    logic      load;
    summary_t  summary;
    addr_set_t addrs;

    // Register incoming bytes
    ihcp_in_stage u_in_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (byte_valid),
        .stall     (byte_stall),
        .item      (byte_item),
        .emit_free (emit_free),
        .advance   (advance),
        .held_item (held_item)
    );

    // Parse header fields and walk the chain
    ihcp_walker u_walker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .load    (load),
        .summary (summary),
        .addrs   (addrs)
    );

    // Send the result items
    ihcp_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .summary   (summary),
        .addrs     (addrs),
        .emit_free (emit_free),
        .valid     (result_valid),
        .stall     (result_stall),
        .item      (result_item)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Byte-stream test of the IPv6 header chain parser core. Packets are built
// from fixed headers, extension chains and payload, then sent with random
// bursts and gaps while the result side stalls on its own pattern. A
// tracking model of the parse state predicts every result item, and each
// accepted result is compared field by field with the oldest prediction.
// ============================================================================
module tb
    import ihcp_pkg::*;
();

    localparam int LIMIT        = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEM_TARGET  = 470;

    // No Next Header: a code the walk does not know
    localparam logic [7:0] NH_NO_NEXT = 8'd59;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result_item;

    ipv6_header_chain_parser_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always #5 clk = ~clk;

    // Parse state tracked per accepted byte
    pos_t        byte_pos;
    pos_t        hdr_start;
    pos_t        hdr_end;
    logic [15:0] pkt_base;
    logic [63:0] fixed_hdr;
    logic [63:0] addr_words [4];
    logic [7:0]  walk_nh;
    logic [7:0]  pend_nh;
    logic        walk_done;
    logic [2:0]  walk_status;

    out_item_t   due_results [$];
    logic [7:0]  pkt [$];

    int error_count = 0;
    int cycle_count = 0;
    int n_bytes = 0;
    int n_packets = 0;
    int n_results = 0;
    int n_checked = 0;
    int status_count [5] = '{0, 0, 0, 0, 0};

    // Sender and receiver pacing
    int gap_max = 4;
    int burst_max = 10;
    int burst_left = 0;
    int stall_pct = 30;
    int stall_run = 0;
    logic stalling = 1'b0;
    int hold_request = 0;
    int hold_left = 0;

    function automatic logic ends_walk(input logic [7:0] nh);
        return nh == NH_TCP || nh == NH_UDP || nh == NH_ICMPV6;
    endfunction

    function automatic logic has_len_field(input logic [7:0] nh);
        return nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_DEST_OPTS;
    endfunction

    function automatic pos_t clamp_pos(input longint v);
        return (v > longint'(POS_MAX)) ? POS_MAX : pos_t'(v);
    endfunction

    task automatic clear_parse();
        byte_pos    = '0;
        pkt_base    = '0;
        fixed_hdr   = '0;
        walk_nh     = '0;
        pend_nh     = '0;
        hdr_start   = FIXED_LEN;
        hdr_end     = FIXED_LEN;
        walk_done   = 1'b0;
        walk_status = ST_TOO_SHORT;
        for (int k = 0; k < 4; k++)
        begin
            addr_words[k] = '0;
        end
    endtask

    // Advance the extension walk by one byte at position p
    task automatic walk_byte(input pos_t p, input logic [7:0] b);
        if (!walk_done && p >= FIXED_LEN)
        begin
            if (hdr_end > hdr_start && p == hdr_end)
            begin
                walk_nh   = pend_nh;
                hdr_start = hdr_end;
            end
            if (p == hdr_start)
            begin
                if (ends_walk(walk_nh))
                begin
                    walk_done   = 1'b1;
                    walk_status = ST_UPPER;
                end
                else if (has_len_field(walk_nh) || walk_nh == NH_FRAGMENT)
                begin
                    pend_nh = b;
                    hdr_end = clamp_pos(longint'(hdr_start) + EXT_UNIT);
                end
                else
                begin
                    walk_done   = 1'b1;
                    walk_status = ST_UNKNOWN;
                end
            end
            else if (longint'(p) == longint'(hdr_start) + 1 && has_len_field(walk_nh))
            begin
                hdr_end = clamp_pos(longint'(hdr_start) + (longint'(b) + 1) * EXT_UNIT);
            end
        end
    endtask

    // Track one accepted byte; on the last byte queue the packet's results
    task automatic parse_byte(input in_item_t it);
        pos_t        p;
        pos_t        start;
        logic [7:0]  b;
        logic [7:0]  proto;
        logic [2:0]  status;
        out_item_t   r;
        int          idx;
        p = byte_pos;
        b = it.data_byte;
        n_bytes++;
        if (p < POS_MAX)
        begin
            if (p == '0)
            begin
                pkt_base = it.base_offset;
            end
            if (p < FIXED_HDR)
            begin
                fixed_hdr = {fixed_hdr[55:0], b};
            end
            else if (p < FIXED_LEN)
            begin
                idx = int'((p - FIXED_HDR) >> 3);
                addr_words[idx] = {addr_words[idx][55:0], b};
            end
            if (p == NH_POS)
            begin
                walk_nh = b;
            end
            walk_byte(p, b);
            byte_pos = p + pos_t'(1);
        end
        if (it.last_byte)
        begin
            r = '0;
            if (byte_pos < FIXED_LEN)
            begin
                r.status      = ST_TOO_SHORT;
                r.last_result = 1'b1;
                due_results.insert(due_results.size(), r);
                n_results++;
            end
            else
            begin
                proto = walk_nh;
                start = hdr_start;
                if (walk_done)
                begin
                    status = walk_status;
                end
                else if (hdr_end > hdr_start)
                begin
                    if (byte_pos >= hdr_end)
                    begin
                        proto  = pend_nh;
                        start  = hdr_end;
                        status = ST_EXHAUSTED;
                    end
                    else
                    begin
                        status = ST_TRUNCATED;
                    end
                end
                else
                begin
                    status = ST_EXHAUSTED;
                end
                r.status            = status;
                r.version           = fixed_hdr[63:60];
                r.tclass            = fixed_hdr[59:52];
                r.flow_id           = fixed_hdr[51:32];
                r.pay_len           = fixed_hdr[31:16];
                r.first_next_header = fixed_hdr[15:8];
                r.hop_lim           = fixed_hdr[7:0];
                r.upper_protocol    = proto;
                r.upper_offset      = pkt_base + start[15:0];
                for (int k = 0; k < 4; k++)
                begin
                    r.address_part = 2'(k);
                    r.address_word = addr_words[k];
                    r.last_result  = (k == 3);
                    due_results.insert(due_results.size(), r);
                    n_results++;
                end
            end
            status_count[int'(r.status)]++;
            clear_parse();
        end
    endtask

    // Offer one item; gaps open between bursts of random length
    task automatic send_byte(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, burst_max);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (byte_stall) @(posedge clk);
        parse_byte(it);
    endtask

    // Send the first cut bytes of the built packet (all when cut is zero)
    task automatic send_packet(input logic [15:0] base, input int cut);
        in_item_t it;
        int       n;
        n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
        for (int i = 0; i < n; i++)
        begin
            it.data_byte   = pkt[i];
            it.base_offset = (i == 0) ? base : 16'($urandom);
            it.last_byte   = (i == n - 1);
            send_byte(it);
        end
        n_packets++;
    endtask

    task automatic append_byte(input logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endtask

    task automatic begin_packet(input logic [7:0] first_nh);
        pkt.delete();
        repeat (40) append_byte(8'($urandom));
        pkt[6] = first_nh;
    endtask

    task automatic add_ext(input logic [7:0] kind, input logic [7:0] nxt,
                           input logic [7:0] len_units);
        int n;
        n = (kind == NH_FRAGMENT) ? EXT_UNIT : (int'(len_units) + 1) * EXT_UNIT;
        append_byte(nxt);
        append_byte((kind == NH_FRAGMENT) ? 8'($urandom) : len_units);
        repeat (n - 2) append_byte(8'($urandom));
    endtask

    task automatic add_payload(input int n);
        repeat (n) append_byte(8'($urandom));
    endtask

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(0, 3))
            0:       return NH_HOP_BY_HOP;
            1:       return NH_ROUTING;
            2:       return NH_DEST_OPTS;
            default: return NH_FRAGMENT;
        endcase
    endfunction

    function automatic logic [7:0] pick_upper();
        case ($urandom_range(0, 2))
            0:       return NH_TCP;
            1:       return NH_UDP;
            default: return NH_ICMPV6;
        endcase
    endfunction

    function automatic logic [7:0] pick_unknown();
        logic [7:0] v;
        do v = 8'($urandom);
        while (ends_walk(v) || has_len_field(v) || v == NH_FRAGMENT);
        return v;
    endfunction

    // Well-formed chain with random content, sometimes cut short or pure noise
    task automatic random_packet();
        logic [7:0] chain [$];
        logic [7:0] term;
        logic [7:0] len_units;
        int         n_ext;
        int         cut;
        int         pick;
        chain.delete();
        n_ext = $urandom_range(0, 3);
        repeat (n_ext) chain.insert(chain.size(), pick_ext());
        term = ($urandom_range(0, 9) == 0) ? pick_unknown() : pick_upper();
        begin_packet((n_ext > 0) ? chain[0] : term);
        for (int i = 0; i < n_ext; i++)
        begin
            len_units = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(3, 7))
                                                    : 8'($urandom_range(0, 2));
            add_ext(chain[i], (i < n_ext - 1) ? chain[i + 1] : term, len_units);
        end
        add_payload(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 24));
        pick = $urandom_range(0, 99);
        cut = 0;
        if (pick < 8)
        begin
            pkt.delete();
            repeat ($urandom_range(1, 90)) append_byte(8'($urandom));
        end
        else if (pick < 18)
        begin
            cut = $urandom_range(1, 39);
        end
        else if (pick < 32)
        begin
            cut = $urandom_range(40, pkt.size());
        end
        send_packet(16'($urandom), cut);
    endtask

    task automatic test_short_packets();
        begin_packet(NH_TCP);
        send_packet(16'h1234, 1);
        begin_packet(NH_TCP);
        send_packet(16'hFFFF, 39);
    endtask

    // All-ones header: unknown first code, offset wraps past 16 bits
    task automatic test_field_extremes();
        pkt.delete();
        repeat (40) append_byte(8'hFF);
        send_packet(16'hFFFF, 0);
    endtask

    task automatic test_upper_and_unknown();
        begin_packet(NH_TCP);
        add_payload(1);
        send_packet(16'($urandom), 0);
        begin_packet(NH_NO_NEXT);
        add_payload(1);
        send_packet(16'hFFF0, 0);
    endtask

    task automatic test_extension_chain();
        begin_packet(NH_HOP_BY_HOP);
        add_ext(NH_HOP_BY_HOP, NH_ROUTING, 8'd0);
        add_ext(NH_ROUTING, NH_FRAGMENT, 8'd1);
        add_ext(NH_FRAGMENT, NH_DEST_OPTS, 8'd0);
        add_ext(NH_DEST_OPTS, NH_ICMPV6, 8'd0);
        add_payload(2);
        send_packet(16'($urandom), 0);
    endtask

    task automatic test_truncation_and_exhaustion();
        // only the next header byte of the extension arrives
        begin_packet(NH_HOP_BY_HOP);
        add_payload(1);
        send_packet(16'($urandom), 0);
        // largest length field, cut well before the header ends
        begin_packet(NH_DEST_OPTS);
        add_ext(NH_DEST_OPTS, NH_TCP, 8'd255);
        send_packet(16'($urandom), 44);
        begin_packet(NH_FRAGMENT);
        add_ext(NH_FRAGMENT, NH_UDP, 8'd0);
        send_packet(16'hFFFF, 0);
    endtask

    // Full rate on both sides, packet ends back to back
    task automatic test_back_to_back();
        gap_max   = 0;
        stall_pct = 0;
        begin_packet(pick_upper());
        add_payload(2);
        send_packet(16'($urandom), 0);
        repeat (3)
        begin
            begin_packet(NH_TCP);
            send_packet(16'($urandom), 1);
        end
        gap_max   = 4;
        stall_pct = 30;
    endtask

    // Hold the receiver off while short packets keep coming
    task automatic test_receiver_hold();
        gap_max = 0;
        hold_request = 400;
        repeat (3)
        begin
            begin_packet(NH_TCP);
            send_packet(16'($urandom), 2);
            begin_packet(NH_TCP);
            send_packet(16'($urandom), 1);
        end
        gap_max = 4;
    endtask

    task automatic test_random_traffic();
        int count;
        count = 0;
        while (n_bytes < ITEM_TARGET)
        begin
            // change pacing every few packets
            if (count % 6 == 0)
            begin
                gap_max   = $urandom_range(0, 6);
                burst_max = $urandom_range(1, 20);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            random_packet();
            count++;
        end
    endtask

    // Stimulus
    initial
    begin
        clear_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_packets();
        test_field_extremes();
        test_upper_and_unknown();
        test_extension_chain();
        test_truncation_and_exhaustion();
        test_back_to_back();
        test_receiver_hold();
        test_random_traffic();
        byte_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d packets (%0d bytes); checked %0d of %0d result items.",
                 n_packets, n_bytes, n_checked, n_results);
        $display("Packets by status: short %0d, upper %0d, unknown %0d, truncated %0d, %s %0d",
                 status_count[ST_TOO_SHORT], status_count[ST_UPPER],
                 status_count[ST_UNKNOWN], status_count[ST_TRUNCATED], "exhausted",
                 status_count[ST_EXHAUSTED]);
        if (error_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Receiver: runs of stall and go, plus a long hold when one is asked for
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (stall_run == 0)
        begin
            stalling  = ($urandom_range(0, 99) < stall_pct);
            stall_run = $urandom_range(1, 6);
        end
        stall_run--;
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= stalling;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, result_item);
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                n_checked++;
                check_field("status", 64'(want.status), 64'(result_item.status));
                check_field("version", 64'(want.version), 64'(result_item.version));
                check_field("tclass", 64'(want.tclass), 64'(result_item.tclass));
                check_field("flow_id", 64'(want.flow_id), 64'(result_item.flow_id));
                check_field("pay_len", 64'(want.pay_len), 64'(result_item.pay_len));
                check_field("hop_lim", 64'(want.hop_lim), 64'(result_item.hop_lim));
                check_field("first_next_header", 64'(want.first_next_header),
                            64'(result_item.first_next_header));
                check_field("upper_protocol", 64'(want.upper_protocol),
                            64'(result_item.upper_protocol));
                check_field("upper_offset", 64'(want.upper_offset),
                            64'(result_item.upper_offset));
                check_field("address_part", 64'(want.address_part),
                            64'(result_item.address_part));
                check_field("address_word", want.address_word, result_item.address_word);
                check_field("last_result", 64'(want.last_result),
                            64'(result_item.last_result));
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d result items outstanding",
                     cycle_count, due_results.size());
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule
